/* design/assert_macros.svh */
// Assertion helpers shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/pce_pkg.sv */
// ----------------------------------------------------------------------------
// pce_pkg
// Types, codes and step functions for the PCI configuration bus enumerator.
// ----------------------------------------------------------------------------
`default_nettype none

package pce_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic OP_START = 1'b0;
	localparam logic OP_DATA  = 1'b1;

	localparam logic [1:0] KIND_READ   = 2'd0;
	localparam logic [1:0] KIND_RECORD = 2'd1;
	localparam logic [1:0] KIND_DONE   = 2'd2;

	localparam logic [7:0]  OFF_ID     = 8'h00;
	localparam logic [7:0]  OFF_CLASS  = 8'h08;
	localparam logic [7:0]  OFF_HEADER = 8'h0E;
	localparam logic [15:0] VENDOR_NONE = 16'hFFFF;
	localparam logic [7:0]  LAST_BUS_RESET = 8'd255;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'b0001,
		PH_ID     = 4'b0010,
		PH_CLASS  = 4'b0100,
		PH_HEADER = 4'b1000
	} phase_t;

	typedef struct packed {
		logic        op;
		logic [31:0] read_data;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] cfg_address;
		logic [7:0]  bus_number;
		logic [4:0]  device_number;
		logic [2:0]  function_number;
		logic [15:0] vendor_code;
		logic [15:0] device_code;
		logic [31:0] class_revision;
		logic [7:0]  header_byte;
		logic        last;
	} rsp_t;

	typedef struct packed {
		phase_t      phase;
		logic [7:0]  bus;
		logic [4:0]  dev;
		logic [2:0]  fn;
		logic        mf;
		logic [31:0] id;
		logic [31:0] cls;
	} scan_t;

	typedef struct packed {
		scan_t st;
		rsp_t  rsp;
	} adv_t;

	localparam scan_t SCAN_RESET = '{phase: PH_IDLE, bus: 8'd0, dev: 5'd0, fn: 3'd0,
		mf: 1'b0, id: 32'd0, cls: 32'd0};

	// Mechanism one address: enable, bus, device, function, dword offset.
	function automatic rsp_t read_req(scan_t s, logic [7:0] off);
		rsp_t r;
		r = '0;
		r.kind = KIND_READ;
		r.cfg_address = {1'b1, 7'd0, s.bus, s.dev, s.fn, off[7:2], 2'b00};
		r.last = 1'b1;
		return r;
	endfunction

	// Step to the next function/device/bus, then issue its id read or finish.
	function automatic adv_t follow(scan_t s, logic [7:0] last_bus);
		adv_t a;
		logic done;
		a.st = s;
		a.rsp = '0;
		done = 1'b0;
		if (s.mf && s.fn != 3'd7) begin
			a.st.fn = s.fn + 3'd1;
		end else begin
			a.st.fn = 3'd0;
			a.st.mf = 1'b0;
			if (s.dev != 5'd31) begin
				a.st.dev = s.dev + 5'd1;
			end else begin
				a.st.dev = 5'd0;
				if (s.bus >= last_bus || s.bus == 8'hFF) begin
					a.st.bus = 8'd0;
					done = 1'b1;
				end else begin
					a.st.bus = s.bus + 8'd1;
				end
			end
		end
		if (done) begin
			a.st.phase = PH_IDLE;
			a.rsp.kind = KIND_DONE;
			a.rsp.last = 1'b1;
		end else begin
			a.st.phase = PH_ID;
			a.rsp = read_req(a.st, OFF_ID);
		end
		return a;
	endfunction

endpackage

`default_nettype wire

/* design/pce_step.sv */
// ----------------------------------------------------------------------------
// pce_step
// Scan sequencer logic: next scan state and up to two results per request.
// ----------------------------------------------------------------------------
`default_nettype none

module pce_step (
	input  pce_pkg::scan_t cur,
	input  logic [7:0]     last_bus,
	input  pce_pkg::req_t  req,
	output pce_pkg::scan_t nxt,
	output logic [1:0]     n_res,
	output pce_pkg::rsp_t  res0,
	output pce_pkg::rsp_t  res1
);

	pce_pkg::scan_t tmp;
	pce_pkg::adv_t  adv;

	always_comb begin
		nxt = cur;
		n_res = 2'd0;
		res0 = '0;
		res1 = '0;
		tmp = cur;
		adv = '0;
		unique case (cur.phase)
			pce_pkg::PH_IDLE: begin
				if (req.op == pce_pkg::OP_START) begin
					nxt.bus = 8'd0;
					nxt.dev = 5'd0;
					nxt.fn = 3'd0;
					nxt.mf = 1'b0;
					nxt.phase = pce_pkg::PH_ID;
					res0 = pce_pkg::read_req(nxt, pce_pkg::OFF_ID);
					n_res = 2'd1;
				end
			end
			pce_pkg::PH_ID: begin
				if (req.op == pce_pkg::OP_DATA) begin
					n_res = 2'd1;
					if (req.read_data[15:0] == pce_pkg::VENDOR_NONE) begin
						// absent: skip this function, or the whole device at function 0
						if (cur.fn == 3'd0) tmp.mf = 1'b0;
						adv = pce_pkg::follow(tmp, last_bus);
						nxt = adv.st;
						res0 = adv.rsp;
					end else begin
						nxt.id = req.read_data;
						nxt.phase = pce_pkg::PH_CLASS;
						res0 = pce_pkg::read_req(cur, pce_pkg::OFF_CLASS);
					end
				end
			end
			pce_pkg::PH_CLASS: begin
				if (req.op == pce_pkg::OP_DATA) begin
					n_res = 2'd1;
					nxt.cls = req.read_data;
					nxt.phase = pce_pkg::PH_HEADER;
					res0 = pce_pkg::read_req(cur, pce_pkg::OFF_HEADER);
				end
			end
			pce_pkg::PH_HEADER: begin
				if (req.op == pce_pkg::OP_DATA) begin
					n_res = 2'd2;
					if (cur.fn == 3'd0) tmp.mf = req.read_data[23];
					res0.kind = pce_pkg::KIND_RECORD;
					res0.bus_number = cur.bus;
					res0.device_number = cur.dev;
					res0.function_number = cur.fn;
					res0.vendor_code = cur.id[15:0];
					res0.device_code = cur.id[31:16];
					res0.class_revision = cur.cls;
					res0.header_byte = req.read_data[23:16];
					adv = pce_pkg::follow(tmp, last_bus);
					nxt = adv.st;
					res1 = adv.rsp;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

`default_nettype wire

/* design/pce_out_queue.sv */
// ----------------------------------------------------------------------------
// pce_out_queue
// Result queue: takes up to two results per cycle, presents the oldest.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pce_out_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [1:0]    push_n,
	input  pce_pkg::rsp_t d0,
	input  pce_pkg::rsp_t d1,
	output logic          room,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output pce_pkg::rsp_t rsp
);

	localparam int unsigned DEPTH = pce_pkg::QUEUE_DEPTH;
	localparam int unsigned CNT_W = pce_pkg::QUEUE_CNT_W;

	pce_pkg::rsp_t          ent_q [DEPTH];
	pce_pkg::rsp_t          ent_d [DEPTH];
	logic [CNT_W-1:0]       cnt_q;
	logic [CNT_W-1:0]       base;
	logic                   pop;

	assign pop = rsp_valid && rsp_ready;
	assign base = cnt_q - CNT_W'(pop);
	assign rsp_valid = (cnt_q != '0);
	assign rsp = ent_q[0];
	assign room = (cnt_q <= CNT_W'(DEPTH - 2));

	// Shift toward the head on a pop, then append behind what stays.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			if (pop && i < DEPTH - 1) ent_d[i] = ent_q[(i + 1) % DEPTH];
			else ent_d[i] = ent_q[i];
			if (push_n != 2'd0 && CNT_W'(i) == base) ent_d[i] = d0;
			if (push_n == 2'd2 && CNT_W'(i) == base + CNT_W'(1)) ent_d[i] = d1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) ent_q[i] <= ent_d[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= base + CNT_W'(push_n);
		end
	end

	`ASSERT_AT(a_cnt_max, clk, arst_n, cnt_q <= CNT_W'(DEPTH), "result queue count beyond depth")
	`ASSERT_AT(a_push_room, clk, arst_n, push_n == 2'd0 || room, "push without room")
	`ASSERT_NEXT(a_pop_push, clk, arst_n, pop && push_n == 2'd0,
		cnt_q == $past(cnt_q) - CNT_W'(1), "pop without push did not drop one entry")

endmodule

`default_nettype wire

/* design/pci_config_bus_enumerator.sv */
// PCI configuration mechanism #1 bus enumerator.
// Request channel (req_valid/req_ready, req): op start begins a scan over
// buses 0..last_bus and devices 0..31; op data returns the dword for the
// last issued config read. Response channel (rsp_valid/rsp_ready, rsp):
// config read addresses, one record per present function, and a finished
// marker; last flags the final response caused by a request.
// Throughput: one request per cycle while req_ready is high; a request
// completing a function gives two responses (record plus next read or
// finish), so the output side sets the pace then. A four-entry result
// queue separates the channels; req_ready is high while it has room
// for two responses, so a stalled receiver holds the block off after
// three more requests at most and nothing is dropped.
// cfg_we writes last_bus (reset 255) at once; write it only when idle.
// Reset: no scan running, queue empty, last_bus back to 255.
// ----------------------------------------------------------------------------
// pci_config_bus_enumerator
// Top level: scan state registers, sequencer logic and result queue.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pci_config_bus_enumerator (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [7:0]    cfg_wdata,
	input  logic          req_valid,
	output logic          req_ready,
	input  pce_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output pce_pkg::rsp_t rsp
);

	pce_pkg::scan_t scan_q;
	pce_pkg::scan_t scan_d;
	logic [7:0]     last_bus_q;
	logic [1:0]     n_res;
	logic [1:0]     push_n;
	pce_pkg::rsp_t  res0;
	pce_pkg::rsp_t  res1;
	logic           fire;

	assign fire = req_valid && req_ready;
	assign push_n = fire ? n_res : 2'd0;

	pce_step u_step (
		.cur      (scan_q),
		.last_bus (last_bus_q),
		.req      (req),
		.nxt      (scan_d),
		.n_res    (n_res),
		.res0     (res0),
		.res1     (res1)
	);

	pce_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.d0        (res0),
		.d1        (res1),
		.room      (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= pce_pkg::SCAN_RESET;
			last_bus_q <= pce_pkg::LAST_BUS_RESET;
		end else begin
			if (fire) scan_q <= scan_d;
			if (cfg_we) last_bus_q <= cfg_wdata;
		end
	end

	`ASSERT_AT(a_phase_hot, clk, arst_n, $onehot(scan_q.phase), "scan phase not one-hot")
	`ASSERT_AT(a_idle_data, clk, arst_n,
		!(fire && scan_q.phase == pce_pkg::PH_IDLE && req.op == pce_pkg::OP_DATA)
		|| n_res == 2'd0, "data while idle produced a response")
	`ASSERT_AT(a_hdr_two, clk, arst_n,
		!(fire && scan_q.phase == pce_pkg::PH_HEADER && req.op == pce_pkg::OP_DATA)
		|| n_res == 2'd2, "header data must give record and follow-up")

endmodule

`default_nettype wire

/* tb/tb_pci_config_bus_enumerator.sv */
// ----------------------------------------------------------------------------
// tb_pci_config_bus_enumerator
// Self-checking bench for the PCI configuration bus enumerator. Drives scan
// starts and returned config dwords, mirrors the scan sequencer to predict
// every read address, device record and finish marker, and compares each
// result in order. Random idling on both channels, a long receiver stall and
// multi-bus scans with tight timing are included.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_pci_config_bus_enumerator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [31:0] CFG_ENABLE   = 32'h8000_0000;
	localparam int          DRAIN_CYCLES = 4;
	localparam int          MAX_REPORTS  = 10;
	localparam int          RANDOM_ITEMS = 700;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          cfg_we    = 1'b0;
	logic [7:0]    cfg_wdata = '0;
	logic          req_valid = 1'b0;
	logic          req_ready;
	pce_pkg::req_t req       = '0;
	logic          rsp_valid;
	logic          rsp_ready = 1'b0;
	pce_pkg::rsp_t rsp;

	int            req_gap_max     = 8;
	int            rsp_stall_max   = 8;
	int            rsp_hold_cycles = 0;
	int            error_count     = 0;
	int            scan_items      = 0;
	pce_pkg::rsp_t expected_rsp[$];

	// Mirror of the scan sequencer
	pce_pkg::phase_t scan_phase    = pce_pkg::PH_IDLE;
	logic [7:0]      scan_last_bus = pce_pkg::LAST_BUS_RESET;
	logic [7:0]      scan_bus      = '0;
	logic [4:0]      scan_dev      = '0;
	logic [2:0]      scan_fn       = '0;
	logic            scan_mf       = 1'b0;
	logic [31:0]     scan_id       = '0;
	logic [31:0]     scan_cls      = '0;

	pci_config_bus_enumerator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic pce_pkg::rsp_t read_rsp(logic [7:0] off);
		pce_pkg::rsp_t r;
		r = '0;
		r.kind = pce_pkg::KIND_READ;
		r.cfg_address = CFG_ENABLE | ({24'd0, scan_bus} << 16) | ({27'd0, scan_dev} << 11)
			| ({29'd0, scan_fn} << 8) | {24'd0, off & 8'hFC};
		r.last = 1'b1;
		return r;
	endfunction

	// Advance function, then device, then bus; queue the next id read or the finish.
	function automatic void step_location();
		pce_pkg::rsp_t r;
		logic done;
		done = 1'b0;
		if (scan_mf && scan_fn != 3'd7) begin
			scan_fn = scan_fn + 3'd1;
		end else begin
			scan_fn = 3'd0;
			scan_mf = 1'b0;
			if (scan_dev != 5'd31) begin
				scan_dev = scan_dev + 5'd1;
			end else begin
				scan_dev = 5'd0;
				// bus 255 always satisfies this, since last_bus is at most 255
				if (scan_bus >= scan_last_bus) begin
					scan_bus = 8'd0;
					done = 1'b1;
				end else begin
					scan_bus = scan_bus + 8'd1;
				end
			end
		end
		if (done) begin
			r = '0;
			r.kind = pce_pkg::KIND_DONE;
			r.last = 1'b1;
			scan_phase = pce_pkg::PH_IDLE;
		end else begin
			r = read_rsp(pce_pkg::OFF_ID);
			scan_phase = pce_pkg::PH_ID;
		end
		expected_rsp.push_back(r);
	endfunction

	function automatic void predict_scan_step(pce_pkg::req_t item);
		pce_pkg::rsp_t rec;
		logic [7:0] hdr;
		if (item.op == pce_pkg::OP_START) begin
			if (scan_phase == pce_pkg::PH_IDLE) begin
				scan_bus = '0;
				scan_dev = '0;
				scan_fn = '0;
				scan_mf = 1'b0;
				scan_phase = pce_pkg::PH_ID;
				expected_rsp.push_back(read_rsp(pce_pkg::OFF_ID));
			end
			return;
		end
		case (scan_phase)
			pce_pkg::PH_ID: begin
				if (item.read_data[15:0] == pce_pkg::VENDOR_NONE) begin
					if (scan_fn == 3'd0)
						scan_mf = 1'b0;
					step_location();
				end else begin
					scan_id = item.read_data;
					scan_phase = pce_pkg::PH_CLASS;
					expected_rsp.push_back(read_rsp(pce_pkg::OFF_CLASS));
				end
			end
			pce_pkg::PH_CLASS: begin
				scan_cls = item.read_data;
				scan_phase = pce_pkg::PH_HEADER;
				expected_rsp.push_back(read_rsp(pce_pkg::OFF_HEADER));
			end
			pce_pkg::PH_HEADER: begin
				hdr = item.read_data[23:16];
				if (scan_fn == 3'd0)
					scan_mf = hdr[7];
				rec = '0;
				rec.kind = pce_pkg::KIND_RECORD;
				rec.bus_number = scan_bus;
				rec.device_number = scan_dev;
				rec.function_number = scan_fn;
				rec.vendor_code = scan_id[15:0];
				rec.device_code = scan_id[31:16];
				rec.class_revision = scan_cls;
				rec.header_byte = hdr;
				expected_rsp.push_back(rec);
				step_location();
			end
			default: begin
			end
		endcase
	endfunction

	function automatic string fmt_rsp(pce_pkg::rsp_t r);
		return $sformatf(
			"kind=%0d addr=%h bdf=%0d/%0d/%0d ven=%h dev=%h cls=%h hdr=%h last=%b",
			r.kind, r.cfg_address, r.bus_number, r.device_number, r.function_number,
			r.vendor_code, r.device_code, r.class_revision, r.header_byte, r.last);
	endfunction

	function automatic void note_failure(string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("%s", msg);
	endfunction

	always @(posedge clk) begin : check_rsp
		pce_pkg::rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsp.size() == 0) begin
				note_failure($sformatf("unexpected result: %s", fmt_rsp(rsp)));
			end else begin
				want = expected_rsp.pop_front();
				if (rsp.kind !== want.kind || rsp.cfg_address !== want.cfg_address
					|| rsp.bus_number !== want.bus_number
					|| rsp.device_number !== want.device_number
					|| rsp.function_number !== want.function_number
					|| rsp.vendor_code !== want.vendor_code
					|| rsp.device_code !== want.device_code
					|| rsp.class_revision !== want.class_revision
					|| rsp.header_byte !== want.header_byte || rsp.last !== want.last) begin
					note_failure($sformatf("mismatch at %0t\n  expected %s\n  actual   %s",
						$realtime, fmt_rsp(want), fmt_rsp(rsp)));
				end
			end
		end
	end

	// Receiver: random stall per result, plus an optional long hold-off.
	initial begin : rsp_drain
		int stall;
		forever begin
			@(negedge clk);
			if (rsp_hold_cycles > 0) begin
				rsp_ready <= 1'b0;
				repeat (rsp_hold_cycles) @(negedge clk);
				rsp_hold_cycles = 0;
			end
			stall = $urandom_range(0, rsp_stall_max);
			if (stall != 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	task automatic send_request(logic item_op, logic [31:0] item_data);
		int gap;
		gap = $urandom_range(0, req_gap_max);
		@(negedge clk);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req <= '{op: item_op, read_data: item_data};
		do @(posedge clk); while (!req_ready);
		predict_scan_step(req);
	endtask

	task automatic release_request();
		@(negedge clk);
		req_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		release_request();
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_last_bus(logic [7:0] value);
		wait_drained();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		scan_last_bus = value;
	endtask

	// Returned dword shaped by the read in flight: presence at the id read,
	// multi-function bit at the header read.
	function automatic logic [31:0] scan_data(int present_pct, int mf_pct);
		logic [31:0] d;
		d = $urandom;
		case (scan_phase)
			pce_pkg::PH_ID: begin
				if ($urandom_range(0, 99) < present_pct) begin
					if (d[15:0] == pce_pkg::VENDOR_NONE)
						d[0] = 1'b0;
				end else begin
					d[15:0] = pce_pkg::VENDOR_NONE;
				end
			end
			pce_pkg::PH_HEADER: d[23] = ($urandom_range(0, 99) < mf_pct);
			default: begin
			end
		endcase
		return d;
	endfunction

	task automatic run_scan(int present_pct, int mf_pct, int noise_pct, int pause_at);
		int n;
		n = 0;
		send_request(pce_pkg::OP_START, $urandom);
		while (scan_phase != pce_pkg::PH_IDLE) begin
			if (n == pause_at) begin
				wait_drained();
				pause_at = -1;
			end
			if ($urandom_range(0, 99) < noise_pct) begin
				send_request(pce_pkg::OP_START, $urandom);
			end else begin
				send_request(pce_pkg::OP_DATA, scan_data(present_pct, mf_pct));
				n++;
			end
		end
		scan_items += n;
	endtask

	task automatic test_idle_data();
		send_request(pce_pkg::OP_DATA, 32'h0000_0000);
		send_request(pce_pkg::OP_DATA, 32'hFFFF_FFFF);
		wait_drained();
	endtask

	task automatic test_function_walk();
		set_last_bus(8'd0);
		send_request(pce_pkg::OP_START, 32'h0000_0000);
		send_request(pce_pkg::OP_START, 32'hFFFF_FFFF);
		// device 0: single function, header bit 7 clear
		send_request(pce_pkg::OP_DATA, 32'hFFFF_0000);
		send_request(pce_pkg::OP_DATA, 32'h0000_0000);
		send_request(pce_pkg::OP_DATA, 32'h007F_0000);
		// device 1: multi-function; later headers do not touch the flag
		send_request(pce_pkg::OP_DATA, 32'h0000_FFFE);
		send_request(pce_pkg::OP_DATA, 32'hFFFF_FFFF);
		send_request(pce_pkg::OP_DATA, 32'hFFFF_FFFF);
		send_request(pce_pkg::OP_DATA, 32'hFFFF_FFFF);
		send_request(pce_pkg::OP_DATA, 32'h1234_5678);
		send_request(pce_pkg::OP_DATA, 32'hA5A5_5A5A);
		send_request(pce_pkg::OP_DATA, 32'h0000_0000);
		repeat (5) send_request(pce_pkg::OP_DATA, 32'h0000_FFFF);
		// remaining devices absent until the finish
		while (scan_phase != pce_pkg::PH_IDLE)
			send_request(pce_pkg::OP_DATA, 32'hFFFF_FFFF);
		send_request(pce_pkg::OP_DATA, 32'h5555_AAAA);
		wait_drained();
	endtask

	task automatic test_bus_limits();
		set_last_bus(8'd1);
		run_scan(15, 20, 0, -1);
		set_last_bus(8'd3);
		req_gap_max = 1;
		rsp_stall_max = 1;
		run_scan(2, 10, 0, -1);
		req_gap_max = 8;
		rsp_stall_max = 8;
	endtask

	task automatic test_backpressure();
		set_last_bus(8'd0);
		req_gap_max = 0;
		rsp_hold_cycles = 80;
		run_scan(50, 20, 0, -1);
		req_gap_max = 8;
	endtask

	task automatic test_sender_pause();
		set_last_bus(8'd1);
		run_scan(40, 20, 5, 10);
	endtask

	task automatic test_random_scans();
		while (scan_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 7) == 0)
				set_last_bus(8'($urandom_range(2, 3)));
			else
				set_last_bus(8'($urandom_range(0, 1)));
			case ($urandom_range(0, 3))
				0: begin
					req_gap_max = 0;
					rsp_stall_max = 0;
				end
				1: begin
					req_gap_max = 8;
					rsp_stall_max = 0;
				end
				2: begin
					req_gap_max = 0;
					rsp_stall_max = 8;
				end
				default: begin
					req_gap_max = 8;
					rsp_stall_max = 8;
				end
			endcase
			if ($urandom_range(0, 3) == 0)
				send_request(pce_pkg::OP_DATA, $urandom);
			run_scan($urandom_range(20, 70), $urandom_range(0, 40), $urandom_range(0, 8), -1);
		end
		req_gap_max = 8;
		rsp_stall_max = 8;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_idle_data();
		test_function_walk();
		test_bus_limits();
		test_backpressure();
		test_sender_pause();
		test_random_scans();
		wait_drained();
		if (error_count == 0)
			$display("tb_pci_config_bus_enumerator passed");
		else
			$display("tb_pci_config_bus_enumerator failed");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("tb_pci_config_bus_enumerator failed");
		$finish;
	end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+design
design/pce_pkg.sv
design/pce_step.sv
design/pce_out_queue.sv
design/pci_config_bus_enumerator.sv
tb/tb_pci_config_bus_enumerator.sv
